[rtl/drss_pkg.sv]
// Shared types, constants and codes for the delayed release slot scheduler.
`default_nettype none

package drss_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned MAX_RESULTS    = 64;
  localparam int unsigned CNT_W          = $clog2(MAX_RESULTS);
  localparam int unsigned CODE_W         = 16;
  localparam int unsigned DELAY_W        = 16;
  localparam int unsigned FRAME_W        = 32;

  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_FRAME    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_FRAME,
    ST_FLUSH
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [FRAME_W-1:0] a;
    logic [FRAME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] sum;
    logic               ge;
  } alu_rsp_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              ovf;
    logic              last;
  } rel_t;

endpackage

`default_nettype wire

[rtl/drss_alu.sv]
// Shared 33-bit adder: due-frame sum for schedules, signed compare for frame scans.
`default_nettype none

module drss_alu
  import drss_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [FRAME_W:0] ext_a;
  logic [FRAME_W:0] ext_b;
  logic [FRAME_W:0] sum;
  logic             sub;

  always_comb begin
    sub   = (req_i.op == ALU_SUB);
    ext_a = {req_i.a[FRAME_W-1], req_i.a};
    ext_b = {req_i.b[FRAME_W-1], req_i.b};
    // subtract as add of the inverted operand plus one
    sum   = ext_a + (sub ? ~ext_b : ext_b) + {{FRAME_W{1'b0}}, sub};
    rsp_o.sum = sum[FRAME_W-1:0];
    rsp_o.ge  = ~sum[FRAME_W];
  end

endmodule

`default_nettype wire

[rtl/drss_ctrl.sv]
// Sequencer, slot table and valid bits: free-slot search and due-slot scan.
`default_nettype none

module drss_ctrl
  import drss_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_action_i,
  input  logic [CODE_W-1:0]  in_code_i,
  input  logic [DELAY_W-1:0] in_delay_i,
  input  logic [FRAME_W-1:0] in_frame_i,
  output alu_req_t           alu_req_o,
  input  alu_rsp_t           alu_rsp_i,
  output logic               push_valid_o,
  output rel_t               push_o,
  input  logic               out_free_i
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               issue_vld_q, issue_vld_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [FRAME_W-1:0] cur_frame_q, cur_frame_d;
  logic               hold_vld_q, hold_vld_d;
  logic [CODE_W-1:0]  hold_code_q, hold_code_d;
  logic               hold_ovf_q, hold_ovf_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SLOT_COUNT-1:0] used_q;

  logic [CODE_W-1:0]  code_mem [SLOT_COUNT];
  logic [FRAME_W-1:0] due_mem  [SLOT_COUNT];
  logic [CODE_W-1:0]  rd_code_q;
  logic [FRAME_W-1:0] rd_due_q;

  logic rd_en, wr_en, set_en, clr_en, hit, stall;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    alu_req_o.a = cur_frame_q;
    if (state_q == ST_SCHED) begin
      alu_req_o.op = ALU_ADD;
      alu_req_o.b  = {{(FRAME_W-DELAY_W){1'b0}}, delay_q};
    end else begin
      alu_req_o.op = ALU_SUB;
      alu_req_o.b  = rd_due_q;
    end
  end

  assign hit   = cmp_vld_q && used_q[cmp_idx_q] && alu_rsp_i.ge;
  assign stall = hit && hold_vld_q && !out_free_i;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    issue_vld_d  = issue_vld_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    code_d       = code_q;
    delay_d      = delay_q;
    cur_frame_d  = cur_frame_q;
    hold_vld_d   = hold_vld_q;
    hold_code_d  = hold_code_q;
    hold_ovf_d   = hold_ovf_q;
    cnt_d        = cnt_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    set_en       = 1'b0;
    clr_en       = 1'b0;
    push_valid_o = 1'b0;
    push_o.code  = hold_code_q;
    push_o.ovf   = hold_ovf_q;
    push_o.last  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          if (in_action_i == ACT_FRAME) begin
            cur_frame_d = in_frame_i;
            issue_vld_d = 1'b1;
            cmp_vld_d   = 1'b0;
            hold_vld_d  = 1'b0;
            cnt_d       = '0;
            state_d     = ST_FRAME;
          end else begin
            code_d  = in_code_i;
            delay_d = (in_delay_i == '0) ? DELAY_W'(1) : in_delay_i;
            state_d = ST_SCHED;
          end
        end
      end

      ST_SCHED: begin
        if (!used_q[idx_q]) begin
          wr_en   = 1'b1;
          set_en  = 1'b1;
          state_d = ST_IDLE;
        end else if (idx_q == LAST_IDX) begin
          // table full: release at once
          hold_vld_d  = 1'b1;
          hold_code_d = code_q;
          hold_ovf_d  = 1'b1;
          state_d     = ST_FLUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_FRAME: begin
        if (!stall) begin
          rd_en     = issue_vld_q;
          cmp_vld_d = issue_vld_q;
          cmp_idx_d = idx_q;
          if (issue_vld_q) begin
            if (idx_q == LAST_IDX) begin
              issue_vld_d = 1'b0;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          if (!issue_vld_q && !cmp_vld_q) begin
            state_d = ST_FLUSH;
          end
          if (hit) begin
            clr_en = 1'b1;
            // hand on the previous hit; it is known not to be the last
            push_valid_o = hold_vld_q;
            push_o.ovf   = 1'b0;
            hold_vld_d   = 1'b1;
            hold_code_d  = rd_code_q;
            hold_ovf_d   = 1'b0;
            cnt_d        = cnt_q + 1'b1;
            if (cnt_q == CNT_W'(MAX_RESULTS - 1)) begin
              issue_vld_d = 1'b0;
              cmp_vld_d   = 1'b0;
              state_d     = ST_FLUSH;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (!hold_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free_i) begin
          push_valid_o = 1'b1;
          push_o.last  = 1'b1;
          hold_vld_d   = 1'b0;
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      issue_vld_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      cur_frame_q <= '0;
      hold_vld_q  <= 1'b0;
      cnt_q       <= '0;
      used_q      <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      issue_vld_q <= issue_vld_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      cur_frame_q <= cur_frame_d;
      hold_vld_q  <= hold_vld_d;
      cnt_q       <= cnt_d;
      if (set_en) begin
        used_q[idx_q] <= 1'b1;
      end
      if (clr_en) begin
        used_q[cmp_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    delay_q     <= delay_d;
    hold_code_q <= hold_code_d;
    hold_ovf_q  <= hold_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      code_mem[idx_q] <= code_q;
      due_mem[idx_q]  <= alu_rsp_i.sum;
    end
    if (rd_en) begin
      rd_code_q <= code_mem[idx_q];
      rd_due_q  <= due_mem[idx_q];
    end
  end

endmodule

`default_nettype wire

[rtl/drss_out.sv]
// Output register for release transfers.
`default_nettype none

module drss_out
  import drss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  rel_t              push_i,
  output logic              out_free_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [CODE_W-1:0] m_axis_tdata_o,
  output logic              m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  logic vld_q;
  rel_t rel_q;

  assign out_free_o      = !vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = rel_q.code;
  assign m_axis_tuser_o  = rel_q.ovf;
  assign m_axis_tlast_o  = rel_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (out_free_o) begin
      vld_q <= push_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && push_valid_i) begin
      rel_q <= push_i;
    end
  end

endmodule

`default_nettype wire

[rtl/delayed_release_slot_scheduler_top.sv]
// Top level of the delayed release slot scheduler.
//
// Keeps SLOT_COUNT release slots (code plus due frame). An item with tuser 0
// schedules its code in the lowest free slot, due at the last frame number
// plus the delay (0 counts as 1); if no slot is free the code comes back at
// once with tuser 1 and tlast 1. An item with tuser 1 sets the frame number
// and releases, lowest slot first, every used slot due at or before it
// (signed compare), at most 64 per item, tlast marking the final one. A
// schedule checks one used bit per cycle; a frame item makes one slot table
// read and one pass through the shared adder per cycle while the output does
// not stall (the scan stops early once 64 slots have released).
// Input is accepted only between items; a finished release may still wait in
// the output register while the next item is taken.
`default_nettype none

module delayed_release_slot_scheduler_top
  import drss_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [15:0] event_code, [31:16] delay_frames, [63:32] frame_number
  input  logic [63:0]       s_axis_tdata_i,
  // [0] action
  input  logic              s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [15:0] release_code
  output logic [CODE_W-1:0] m_axis_tdata_o,
  // [0] overflow
  output logic              m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     push_valid;
  rel_t     push;
  logic     out_free;

  drss_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_code_i   (s_axis_tdata_i[15:0]),
    .in_delay_i  (s_axis_tdata_i[31:16]),
    .in_frame_i  (s_axis_tdata_i[63:32]),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .push_valid_o(push_valid),
    .push_o      (push),
    .out_free_i  (out_free)
  );

  drss_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  drss_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_valid_i   (push_valid),
    .push_i         (push),
    .out_free_o     (out_free),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[rtl/drss_checker.sv]
// Port-level checks for the scheduler top and their bind.
`default_nettype none

module drss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // a held release keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("release payload changed while stalled");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("release dropped while stalled");

  // an overflow release is always the only one of its item
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("overflow release without tlast");

  // every item keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken back to back");

endmodule

bind delayed_release_slot_scheduler_top drss_checker u_drss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

`default_nettype wire
